// ===== src/rsh_pkg.sv =====
// ---------------------------------------------------------------------------
// rsh_pkg: shared constants and types for the refcounted string heap
// Store geometry, opcodes, controller states, datapath commands and status.
// ---------------------------------------------------------------------------
package rsh_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int MAX_HOLES   = 32;
    localparam int REF_LIMIT   = 255;

    localparam int AW = $clog2(STORE_BYTES);      // store address
    localparam int PW = $clog2(STORE_BYTES + 1);  // position / length
    localparam int HW = $clog2(MAX_HOLES);        // hole index
    localparam int TW = $clog2(MAX_HOLES + 1);    // hole count
    localparam int CW = 8;                        // reference count

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_ADDREF  = 2'd1;
    localparam logic [1:0] OP_DROPREF = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_AINIT,
        S_SCAN,
        S_CHECK,
        S_CRD,
        S_CWR,
        S_HUPD,
        S_HLAST,
        S_REF,
        S_MRD,
        S_MCHK,
        S_MINIT,
        S_MSCAN,
        S_APP,
        S_FAOK,
        S_FAFAIL,
        S_FREF
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_AINIT,
        CMD_SCAN,
        CMD_CWR,
        CMD_NUL,
        CMD_HUPD,
        CMD_HLAST,
        CMD_REF,
        CMD_MCHK,
        CMD_MINIT,
        CMD_MSCAN,
        CMD_APP,
        CMD_RES_AOK,
        CMD_RES_AFAIL
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic fit;
        logic scan_end;
        logic range_ok;
        logic copy_more;
        logic remain_zero;
        logic rel_needed;
        logic meas_in;
        logic byte_nz;
        logic merged;
        logic merge_end;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        dp_cmd_t cmd;
        logic    res_ref;   // load a reference-count result
    } dp_ctrl_t;

endpackage

// ===== src/rsh_req_if.sv =====
// ---------------------------------------------------------------------------
// rsh_req_if: request channel
// Valid/ready channel carrying one heap operation.
// ---------------------------------------------------------------------------
interface rsh_req_if;
    import rsh_pkg::*;

    logic          valid;
    logic          ready;
    logic [1:0]    opcode;
    logic [7:0]    char_byte;
    logic          last_char;
    logic          empty_string;
    logic [AW-1:0] position;

    modport source (output valid, opcode, char_byte, last_char, empty_string, position,
                    input ready);
    modport sink   (input valid, opcode, char_byte, last_char, empty_string, position,
                    output ready);
endinterface

// ===== src/rsh_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rsh_rsp_if: response channel
// Valid/ready channel carrying one allocation or reference result.
// ---------------------------------------------------------------------------
interface rsh_rsp_if;
    import rsh_pkg::*;

    logic          valid;
    logic          ready;
    logic          kind;
    logic [PW-1:0] alloc_position;
    logic [CW-1:0] ref_count;
    logic          hole_overflow;

    modport source (output valid, kind, alloc_position, ref_count, hole_overflow,
                    input ready);
    modport sink   (input valid, kind, alloc_position, ref_count, hole_overflow,
                    output ready);
endinterface

// ===== src/refcounted_string_heap_allocator_top.sv =====
// ---------------------------------------------------------------------------
// refcounted_string_heap_allocator_top: reference-counted string heap
// Byte store with a hole list and per-string reference counts.
// ---------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   opcode, char_byte, last_char, empty_string, position
//  rsp      out  kind, alloc_position, ref_count, hole_overflow
//
//  Reset: rst_n clears control state, then a sweep zeroes all 1024 entries
//  of the count RAM, one entry a cycle; req.ready stays low during the sweep.
//  Steps: a final character runs init, a hole scan, a range check, a copy
//  of the staged bytes through the staging RAM read port, the terminating
//  NUL and count write, a hole update (plus a hole-list trim when the hole
//  is used up) and the result. Add-reference runs the count update and the
//  result. A drop that releases also measures the string byte by byte,
//  then scans the holes to merge, appending a hole when none merges.
//  One operation is in flight at a time; a result waiting in the output
//  register does not stop the next transfer, only the next result.
// ---------------------------------------------------------------------------
module refcounted_string_heap_allocator_top (
    input logic      clk,
    input logic      rst_n,
    rsh_req_if.sink   req,
    rsh_rsp_if.source rsp
);
    import rsh_pkg::*;

    dp_ctrl_t   ctl;   // controller to datapath
    dp_status_t st;    // datapath to controller

    rsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_last   (req.last_char),
        .in_ready  (req.ready),
        .st        (st),
        .ctl       (ctl)
    );

    rsh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .st          (st),
        .in_opcode   (req.opcode),
        .in_char     (req.char_byte),
        .in_last     (req.last_char),
        .in_empty    (req.empty_string),
        .in_position (req.position),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_kind    (rsp.kind),
        .out_pos     (rsp.alloc_position),
        .out_cnt     (rsp.ref_count),
        .out_ovf     (rsp.hole_overflow)
    );
endmodule

// ===== src/rsh_ram.sv =====
// ---------------------------------------------------------------------------
// rsh_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/rsh_ctrl.sv =====
// ---------------------------------------------------------------------------
// rsh_ctrl: heap controller
// Sequences clear, allocate, reference and release steps of the datapath.
// ---------------------------------------------------------------------------
module rsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_opcode,
    input  logic                in_last,
    output logic                in_ready,
    input  rsh_pkg::dp_status_t st,
    output rsh_pkg::dp_ctrl_t   ctl
);
    import rsh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctl.cmd     = CMD_NONE;
        ctl.res_ref = 1'b0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.cmd = CMD_CLEAR;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cmd = CMD_ACCEPT;
                    if (in_opcode == OP_APPEND)
                    begin
                        if (in_last) state_next = S_AINIT;
                    end
                    else if (in_opcode == OP_ADDREF || in_opcode == OP_DROPREF)
                    begin
                        state_next = S_REF;
                    end
                end
            end
            S_AINIT:
            begin
                ctl.cmd    = CMD_AINIT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ctl.cmd = CMD_SCAN;
                if (st.fit)           state_next = S_CHECK;
                else if (st.scan_end) state_next = S_FAFAIL;
            end
            S_CHECK:
            begin
                state_next = st.range_ok ? S_CRD : S_FAFAIL;
            end
            S_CRD:
            begin
                if (st.copy_more)
                begin
                    state_next = S_CWR;
                end
                else
                begin
                    ctl.cmd    = CMD_NUL;
                    state_next = S_HUPD;
                end
            end
            S_CWR:
            begin
                ctl.cmd    = CMD_CWR;
                state_next = S_CRD;
            end
            S_HUPD:
            begin
                ctl.cmd    = CMD_HUPD;
                state_next = st.remain_zero ? S_HLAST : S_FAOK;
            end
            S_HLAST:
            begin
                ctl.cmd    = CMD_HLAST;
                state_next = S_FAOK;
            end
            S_REF:
            begin
                ctl.cmd    = CMD_REF;
                state_next = st.rel_needed ? S_MRD : S_FREF;
            end
            S_MRD:
            begin
                state_next = st.meas_in ? S_MCHK : S_MINIT;
            end
            S_MCHK:
            begin
                ctl.cmd    = CMD_MCHK;
                state_next = st.byte_nz ? S_MRD : S_MINIT;
            end
            S_MINIT:
            begin
                ctl.cmd    = CMD_MINIT;
                state_next = S_MSCAN;
            end
            S_MSCAN:
            begin
                ctl.cmd = CMD_MSCAN;
                if (st.merged)         state_next = S_FREF;
                else if (st.merge_end) state_next = S_APP;
            end
            S_APP:
            begin
                ctl.cmd    = CMD_APP;
                state_next = S_FREF;
            end
            S_FAOK:
            begin
                if (!st.out_busy)
                begin
                    ctl.cmd    = CMD_RES_AOK;
                    state_next = S_IDLE;
                end
            end
            S_FAFAIL:
            begin
                if (!st.out_busy)
                begin
                    ctl.cmd    = CMD_RES_AFAIL;
                    state_next = S_IDLE;
                end
            end
            S_FREF:
            begin
                if (!st.out_busy)
                begin
                    ctl.res_ref = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== src/rsh_dp.sv =====
// ---------------------------------------------------------------------------
// rsh_dp: heap datapath
// Store, staging and count RAMs, hole list, counters and result register.
// ---------------------------------------------------------------------------
module rsh_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsh_pkg::dp_ctrl_t     ctl,
    output rsh_pkg::dp_status_t   st,
    input  logic [1:0]            in_opcode,
    input  logic [7:0]            in_char,
    input  logic                  in_last,
    input  logic                  in_empty,
    input  logic [rsh_pkg::AW-1:0] in_position,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_kind,
    output logic [rsh_pkg::PW-1:0] out_pos,
    output logic [rsh_pkg::CW-1:0] out_cnt,
    output logic                  out_ovf
);
    import rsh_pkg::*;

    localparam logic [PW-1:0] STORE_P = PW'(STORE_BYTES);

    logic [PW-1:0] stg_len_reg;
    logic [PW-1:0] needed_reg;
    logic [PW-1:0] start_reg;
    logic [PW-1:0] k_reg;
    logic [AW-1:0] pos_reg;
    logic [1:0]    op_reg;
    logic [HW-1:0] hidx_reg;
    logic [HW-1:0] isave_reg;
    logic [TW-1:0] total_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [PW-1:0] hs_reg [MAX_HOLES];
    logic [PW-1:0] hz_reg [MAX_HOLES];

    // hole list write port
    logic          hw_en;
    logic [HW-1:0] hw_idx;
    logic [PW-1:0] hw_s, hw_z;

    logic [PW-1:0] hs_rd, hz_rd;
    logic [PW-1:0] remain, next_pos, pos_ext;
    logic [PW:0]   hole_end;
    logic [HW-1:0] last_idx;

    // RAM ports
    logic          stg_we;
    logic [7:0]    stg_rdata;
    logic          str_we;
    logic [AW-1:0] str_waddr;
    logic [7:0]    str_wdata, str_rdata;
    logic          ref_we;
    logic [AW-1:0] ref_waddr;
    logic [CW-1:0] ref_wdata, ref_rdata;

    assign hs_rd    = hs_reg[hidx_reg];
    assign hz_rd    = hz_reg[hidx_reg];
    assign pos_ext  = PW'(pos_reg);
    assign remain   = hz_rd - needed_reg;
    assign next_pos = pos_ext + k_reg;
    assign hole_end = {1'b0, hs_rd} + {1'b0, hz_rd};
    assign last_idx = HW'(total_reg - TW'(1));

    assign stg_we = (ctl.cmd == CMD_ACCEPT) && (in_opcode == OP_APPEND)
                    && !(in_last && in_empty) && (in_char != 8'd0)
                    && (stg_len_reg < STORE_P);

    rsh_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_stg (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_len_reg[AW-1:0]),
        .wdata (in_char),
        .raddr (k_reg[AW-1:0]),
        .rdata (stg_rdata)
    );

    rsh_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_str (
        .clk   (clk),
        .we    (str_we),
        .waddr (str_waddr),
        .wdata (str_wdata),
        .raddr (next_pos[AW-1:0]),
        .rdata (str_rdata)
    );

    rsh_ram #(.WIDTH(CW), .DEPTH(STORE_BYTES)) u_ref (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (in_position),
        .rdata (ref_rdata)
    );

    // status
    always_comb
    begin
        st.clr_last    = (k_reg[AW-1:0] == AW'(STORE_BYTES - 1));
        st.fit         = (hz_rd >= needed_reg);
        st.scan_end    = (hidx_reg == '0);
        st.range_ok    = (start_reg < STORE_P) && (needed_reg <= STORE_P - start_reg);
        st.copy_more   = (k_reg < stg_len_reg);
        st.remain_zero = (remain == '0);
        st.rel_needed  = (op_reg == OP_DROPREF) && (ref_rdata == CW'(1));
        st.meas_in     = (next_pos < STORE_P);
        st.byte_nz     = (str_rdata != 8'd0);
        st.merged      = (hs_rd == next_pos) || (hole_end == {1'b0, pos_ext});
        st.merge_end   = (hidx_reg == last_idx);
        st.out_busy    = out_valid;
    end

    // RAM writes and hole list write
    always_comb
    begin
        str_we    = 1'b0;
        str_waddr = AW'(start_reg + k_reg);
        str_wdata = stg_rdata;
        ref_we    = 1'b0;
        ref_waddr = start_reg[AW-1:0];
        ref_wdata = CW'(1);
        hw_en     = 1'b0;
        hw_idx    = hidx_reg;
        hw_s      = hs_rd;
        hw_z      = hz_rd;
        unique case (ctl.cmd)
            CMD_CLEAR:
            begin
                ref_we    = 1'b1;
                ref_waddr = k_reg[AW-1:0];
                ref_wdata = '0;
            end
            CMD_CWR:
            begin
                str_we = 1'b1;
            end
            CMD_NUL:
            begin
                str_we    = 1'b1;
                str_waddr = AW'(start_reg + stg_len_reg);
                str_wdata = 8'd0;
                ref_we    = 1'b1;
            end
            CMD_HUPD:
            begin
                hw_en = !st.remain_zero;
                hw_s  = start_reg + needed_reg;
                hw_z  = remain;
            end
            CMD_HLAST:
            begin
                hw_idx = isave_reg;
                if (total_reg == TW'(1))
                begin
                    hw_en = 1'b1;
                    hw_s  = STORE_P;
                    hw_z  = '0;
                end
                else
                begin
                    hw_en = (isave_reg < hidx_reg);
                end
            end
            CMD_REF:
            begin
                ref_waddr = pos_reg;
                if (op_reg == OP_ADDREF)
                begin
                    ref_we    = (ref_rdata != '0) && (ref_rdata < CW'(REF_LIMIT));
                    ref_wdata = ref_rdata + CW'(1);
                end
                else
                begin
                    ref_we    = (ref_rdata != '0);
                    ref_wdata = ref_rdata - CW'(1);
                end
            end
            CMD_MSCAN:
            begin
                hw_en = st.merged;
                hw_z  = hz_rd + k_reg;
                if (hs_rd == next_pos) hw_s = pos_ext;
            end
            CMD_APP:
            begin
                hw_en  = (total_reg < TW'(MAX_HOLES));
                hw_idx = total_reg[HW-1:0];
                hw_s   = pos_ext;
                hw_z   = k_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_HOLES; i++)
            begin
                hs_reg[i] <= '0;
                hz_reg[i] <= (i == 0) ? STORE_P : '0;
            end
            total_reg   <= TW'(1);
            stg_len_reg <= '0;
            k_reg       <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (hw_en)
            begin
                hs_reg[hw_idx] <= hw_s;
                hz_reg[hw_idx] <= hw_z;
            end
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (stg_we)
            begin
                stg_len_reg <= stg_len_reg + PW'(1);
            end
            unique case (ctl.cmd)
                CMD_CLEAR, CMD_CWR, CMD_MCHK:
                begin
                    k_reg <= k_reg + PW'(1);
                end
                CMD_AINIT:
                begin
                    needed_reg <= stg_len_reg + PW'(1);
                    hidx_reg   <= last_idx;
                    k_reg      <= '0;
                end
                CMD_SCAN:
                begin
                    if (st.fit) start_reg <= hs_rd;
                    else        hidx_reg  <= hidx_reg - HW'(1);
                end
                CMD_HUPD:
                begin
                    isave_reg <= hidx_reg;
                    hidx_reg  <= last_idx;
                end
                CMD_HLAST:
                begin
                    if (total_reg != TW'(1)) total_reg <= total_reg - TW'(1);
                end
                CMD_REF:
                begin
                    k_reg   <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= '0;
                    if (op_reg == OP_ADDREF)
                    begin
                        if (ref_rdata != '0 && ref_rdata < CW'(REF_LIMIT))
                            cnt_reg <= ref_rdata + CW'(1);
                    end
                    else if (ref_rdata != '0)
                    begin
                        cnt_reg <= ref_rdata - CW'(1);
                    end
                end
                CMD_MINIT:
                begin
                    hidx_reg <= '0;
                end
                CMD_MSCAN:
                begin
                    if (!st.merged) hidx_reg <= hidx_reg + HW'(1);
                end
                CMD_APP:
                begin
                    if (total_reg < TW'(MAX_HOLES)) total_reg <= total_reg + TW'(1);
                    else                            ovf_reg   <= 1'b1;
                end
                CMD_RES_AOK, CMD_RES_AFAIL:
                begin
                    stg_len_reg <= '0;
                    out_valid   <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (ctl.res_ref)
            begin
                out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_ACCEPT)
        begin
            pos_reg <= in_position;
            op_reg  <= in_opcode;
        end
        if (ctl.cmd == CMD_RES_AOK)
        begin
            out_kind <= 1'b0;
            out_pos  <= start_reg;
            out_cnt  <= CW'(1);
            out_ovf  <= 1'b0;
        end
        else if (ctl.cmd == CMD_RES_AFAIL)
        begin
            out_kind <= 1'b0;
            out_pos  <= STORE_P;
            out_cnt  <= '0;
            out_ovf  <= 1'b0;
        end
        else if (ctl.res_ref)
        begin
            out_kind <= 1'b1;
            out_pos  <= '0;
            out_cnt  <= cnt_reg;
            out_ovf  <= ovf_reg;
        end
    end
endmodule

// ===== src/rsh_checker.sv =====
// ---------------------------------------------------------------------------
// rsh_checker: port-level checks for the string heap
// Result hold and result field consistency.
// ---------------------------------------------------------------------------
module rsh_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic                   rsp_kind,
    input logic [rsh_pkg::PW-1:0] rsp_pos,
    input logic [rsh_pkg::CW-1:0] rsp_cnt,
    input logic                   rsp_ovf
);
    import rsh_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos) && $stable(rsp_cnt))
        else $error("result changed while stalled");

    a_ref_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind |-> rsp_pos == '0)
        else $error("reference result with nonzero position");

    a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_kind |->
            (rsp_pos == PW'(STORE_BYTES) && rsp_cnt == '0)
            || (rsp_pos < PW'(STORE_BYTES) && rsp_cnt == CW'(1)))
        else $error("allocation result inconsistent");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ovf |-> rsp_kind && rsp_cnt == '0)
        else $error("overflow flag on wrong result");
endmodule

bind refcounted_string_heap_allocator_top rsh_checker u_rsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_pos   (rsp.alloc_position),
    .rsp_cnt   (rsp.ref_count),
    .rsp_ovf   (rsp.hole_overflow)
);

// ===== bench/tb_refcounted_string_heap_allocator_top.sv =====
// ---------------------------------------------------------------------------
// tb_refcounted_string_heap_allocator_top: self-checking bench for the heap
// Drives strings and reference operations with random bursts and gaps,
// predicts every result with a local model of the heap and compares fields.
// ---------------------------------------------------------------------------
module tb_refcounted_string_heap_allocator_top;
    import rsh_pkg::*;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_byte;
        logic       last_char;
        logic       empty_string;
        logic [9:0] position;
    } heap_op_t;

    typedef struct packed {
        logic        kind;
        logic [10:0] alloc_position;
        logic [7:0]  ref_count;
        logic        hole_overflow;
    } heap_res_t;

    // Heap predictor plus the queue of results it expects.
    class heap_scoreboard;
        logic [7:0]  store_mem [STORE_BYTES];
        logic [7:0]  counts [STORE_BYTES];
        int unsigned hstart [MAX_HOLES];
        int unsigned hsize [MAX_HOLES];
        int unsigned htotal;
        logic [7:0]  staged [STORE_BYTES];
        int unsigned slen;
        heap_res_t   pending [$];
        int          mismatches;

        function new();
            foreach (store_mem[i]) store_mem[i] = 8'd0;
            foreach (counts[i]) counts[i] = 8'd0;
            foreach (hstart[i]) begin hstart[i] = 0; hsize[i] = 0; end
            hsize[0] = STORE_BYTES;
            htotal = 1;
            slen = 0;
            mismatches = 0;
        endfunction

        function int unsigned place_string();
            int unsigned need, last, idx, k, st, remain;
            bit found;
            need = slen + 1;
            found = 0;
            idx = 0;
            if (htotal == 0 || htotal > MAX_HOLES) return STORE_BYTES;
            last = htotal - 1;
            for (k = 0; k < htotal; k++) begin
                idx = last - k;
                if (hsize[idx] >= need) begin found = 1; break; end
            end
            if (!found) return STORE_BYTES;
            st = hstart[idx];
            if (st >= STORE_BYTES || need > STORE_BYTES - st) return STORE_BYTES;
            for (k = 0; k < slen; k++) store_mem[st + k] = staged[k];
            store_mem[st + slen] = 8'd0;
            counts[st] = 8'd1;
            remain = hsize[idx] - need;
            if (remain > 0) begin
                hstart[idx] = st + need;
                hsize[idx] = remain;
                return st;
            end
            if (idx < last) begin
                hstart[idx] = hstart[last];
                hsize[idx] = hsize[last];
            end
            if (htotal == 1) begin
                hstart[idx] = STORE_BYTES;
                hsize[idx] = 0;
            end else htotal--;
            return st;
        endfunction

        function bit free_string(int unsigned p);
            int unsigned len, nxt, i;
            len = 0;
            while (p + len < STORE_BYTES && store_mem[p + len] != 8'd0) len++;
            if (p + len < STORE_BYTES) len++;
            nxt = p + len;
            for (i = 0; i < htotal && i < MAX_HOLES; i++) begin
                if (hstart[i] == nxt) begin
                    hstart[i] = p;
                    hsize[i] += len;
                    return 0;
                end
                if (hstart[i] + hsize[i] == p) begin
                    hsize[i] += len;
                    return 0;
                end
            end
            if (htotal < MAX_HOLES) begin
                hstart[htotal] = p;
                hsize[htotal] = len;
                htotal++;
                return 0;
            end
            return 1;
        endfunction

        // Note one accepted request and queue the result it causes.
        function void note_request(heap_op_t op);
            heap_res_t r;
            int unsigned at, c;
            r = '0;
            if (op.opcode == OP_APPEND) begin
                if (!(op.last_char && op.empty_string) && op.char_byte != 8'd0
                    && slen < STORE_BYTES) begin
                    staged[slen] = op.char_byte;
                    slen++;
                end
                if (!op.last_char) return;
                at = place_string();
                slen = 0;
                r.alloc_position = 11'(at);
                r.ref_count = (at < STORE_BYTES) ? 8'd1 : 8'd0;
                pending.insert(pending.size(), r);
            end else if (op.opcode == OP_ADDREF) begin
                r.kind = 1'b1;
                c = counts[op.position];
                if (c == 0 || c >= REF_LIMIT) c = 0;
                else begin
                    c++;
                    counts[op.position] = 8'(c);
                end
                r.ref_count = 8'(c);
                pending.insert(pending.size(), r);
            end else if (op.opcode == OP_DROPREF) begin
                r.kind = 1'b1;
                if (counts[op.position] != 8'd0) begin
                    counts[op.position] = counts[op.position] - 8'd1;
                    r.ref_count = counts[op.position];
                    if (counts[op.position] == 8'd0)
                        r.hole_overflow = free_string(op.position);
                end
                pending.insert(pending.size(), r);
            end
        endfunction

        function void check_result(heap_res_t got);
            heap_res_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp kind %0d pos %0d cnt %0d ovf %0d, got %0d %0d %0d %0d",
                             exp_r.kind, exp_r.alloc_position, exp_r.ref_count,
                             exp_r.hole_overflow, got.kind, got.alloc_position,
                             got.ref_count, got.hole_overflow);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rsh_req_if req ();
    rsh_rsp_if rsp ();

    refcounted_string_heap_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    heap_scoreboard sb;
    int unsigned    cycle_count;
    bit             hold_off;       // long receiver stall request
    int unsigned    live_pos [$];   // starts of strings believed live

    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sample outputs at the rising edge; transfers are checked here.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request({req.opcode, req.char_byte, req.last_char,
                             req.empty_string, req.position});
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result({rsp.kind, rsp.alloc_position, rsp.ref_count,
                             rsp.hole_overflow});
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    initial
    begin
        int unsigned mode;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            mode = (cycle_count / 512) % 4;
            if (mode == 0) rsp.ready <= 1'b1;
            else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
            else if (mode == 2) rsp.ready <= ($urandom_range(0, 3) == 0);
            else rsp.ready <= ((cycle_count % 7) < 4);
        end
    end

    int unsigned burst_left;

    // Present one request and hold it until the transfer; bursts and gaps.
    // Blocking writes at the falling edge: a release followed by the next
    // request in the same step leaves valid high without a glitch.
    task automatic send_op(heap_op_t op);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
            begin
                req.valid = 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
        burst_left--;
        req.valid        = 1'b1;
        req.opcode       = op.opcode;
        req.char_byte    = op.char_byte;
        req.last_char    = op.last_char;
        req.empty_string = op.empty_string;
        req.position     = op.position;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic send_string(int unsigned len, bit use_empty);
        heap_op_t op;
        int unsigned i;
        for (i = 0; i < len; i++)
        begin
            op = '0;
            op.opcode = OP_APPEND;
            op.char_byte = $urandom_range(1, 255);
            op.position = $urandom;
            op.last_char = (i == len - 1) && !use_empty;
            send_op(op);
        end
        if (use_empty || len == 0)
        begin
            op = '0;
            op.opcode = OP_APPEND;
            op.char_byte = $urandom;
            op.last_char = 1'b1;
            op.empty_string = 1'b1;
            op.position = $urandom;
            send_op(op);
        end
    endtask

    task automatic send_ref(logic [1:0] opc, int unsigned p);
        heap_op_t op;
        op = '0;
        op.opcode = opc;
        op.char_byte = $urandom;
        op.last_char = $urandom;
        op.empty_string = $urandom;
        op.position = p;
        send_op(op);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    // Add a string and remember its start if allocation will succeed.
    task automatic add_tracked(int unsigned len, bit use_empty);
        int unsigned depth;
        depth = sb.pending.size();
        send_string(len, use_empty);
        @(posedge clk);
        if (sb.pending.size() > depth)
            if (sb.pending[$].alloc_position < STORE_BYTES)
                live_pos.insert(live_pos.size(), sb.pending[$].alloc_position);
    endtask

    initial
    begin
        heap_op_t op;
        int unsigned n, k, p, choice;
        sb = new();
        cycle_count = 0;
        hold_off = 1'b0;
        burst_left = 0;
        req.valid = 1'b0;
        req.opcode = OP_APPEND;
        req.char_byte = 8'd0;
        req.last_char = 1'b0;
        req.empty_string = 1'b0;
        req.position = '0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty string, zero char on last, extreme chars, refs.
        add_tracked(0, 1'b1);
        op = '0; op.opcode = OP_APPEND; op.char_byte = 8'hFF; send_op(op);
        op.char_byte = 8'h01; send_op(op);
        op.char_byte = 8'h00; op.last_char = 1'b1; send_op(op);
        add_tracked(5, 1'b0);
        send_ref(OP_ADDREF, 0);
        send_ref(OP_ADDREF, 1023);          // never allocated: refused
        send_ref(OP_DROPREF, 1023);         // drop on zero
        send_ref(OP_DROPREF, 0);
        send_ref(OP_DROPREF, 0);            // release, adds a hole
        op = '0; op.opcode = 2'd3; op.position = 10'h3FF; op.char_byte = 8'hFF;
        op.last_char = 1'b1; op.empty_string = 1'b1;
        send_op(op);                        // unused opcode
        drain();

        // Reference count saturation on one string.
        add_tracked(3, 1'b0);
        p = live_pos[$];
        for (k = 0; k < 256; k++) send_ref(OP_ADDREF, p);
        for (k = 0; k < 255; k++) send_ref(OP_DROPREF, p);
        live_pos.delete(live_pos.size() - 1);
        drain();

        // Sender keeps offering while the receiver holds off.
        hold_off = 1'b1;
        for (k = 0; k < 20; k++) send_ref(OP_ADDREF, $urandom_range(0, 1023));
        drain();

        // Random part: mostly live strings with ref ops; some noise.
        for (n = 0; n < 120; n++)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 35)
                add_tracked($urandom_range(1, 12), $urandom_range(0, 5) == 0);
            else if (choice < 38)
                add_tracked($urandom_range(20, 60), 1'b0);
            else if (choice < 55 && live_pos.size() != 0)
                send_ref(OP_ADDREF, live_pos[$urandom_range(0, live_pos.size() - 1)]);
            else if (choice < 85 && live_pos.size() != 0)
            begin
                k = $urandom_range(0, live_pos.size() - 1);
                p = live_pos[k];
                send_ref(OP_DROPREF, p);
                @(posedge clk);
                if (sb.counts[p] == 8'd0) live_pos.delete(k);
            end
            else if (choice < 95)
                send_ref($urandom_range(1, 2), $urandom_range(0, 1023));
            else
                send_ref(2'd3, $urandom_range(0, 1023));
            if (n == 60) drain();
        end

        drain();
        repeat (3000) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
